// ===== hdl/glpm_pkg.sv =====
// Shared types and constants for the slack-and-yield material point.
// Used by glpm_cascade, glpm_state and gap_lag_plastic_material_point.
`default_nettype none

package glpm_pkg;

  // Item kinds
  localparam logic [1:0] KIND_TRIAL   = 2'd0;
  localparam logic [1:0] KIND_COMMIT  = 2'd1;
  localparam logic [1:0] KIND_REVERT  = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // Branch codes
  localparam logic [2:0] BR_INIT = 3'd0;
  localparam logic [2:0] BR_POS  = 3'd1;
  localparam logic [2:0] BR_NEG  = 3'd2;
  localparam logic [2:0] BR_LAGP = 3'd3;
  localparam logic [2:0] BR_LAGN = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_YIELD_POS = 2'd0;
  localparam logic [1:0] CFG_YIELD_NEG = 2'd1;
  localparam logic [1:0] CFG_LAG_WIDTH = 2'd2;

  // Lag width after reset: 0.05 in Q8.24
  localparam logic [30:0] LAG_RESET = 31'd838861;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] strain;
  } glpm_in_t;

  typedef struct packed {
    logic signed [31:0] stress;
    logic [2:0]         branch;
    logic signed [31:0] reversal_strain;
  } glpm_out_t;

  // Trial-side result of one strain evaluation
  typedef struct packed {
    logic signed [31:0] stress;
    logic [2:0]         branch;
    logic signed [31:0] reversal;
  } glpm_trial_t;

endpackage

`default_nettype wire

// ===== hdl/glpm_cascade.sv =====
// Branch cascade for one trial strain: picks stress, branch and reversal.
// Pure combinational; depends on glpm_pkg.
`default_nettype none

module glpm_cascade import glpm_pkg::*; (
  input  wire logic signed [31:0] eps,
  input  wire logic signed [31:0] cs,
  input  wire logic signed [31:0] rv,
  input  wire logic [2:0]         cbr,
  input  wire logic [30:0]        lag,
  input  wire logic [30:0]        ys_pos,
  input  wire logic signed [31:0] ys_neg,
  input  wire glpm_trial_t        cur,
  output glpm_trial_t             nxt
);

  logic signed [35:0] eps_w;
  logic signed [35:0] cs_w;
  logic signed [35:0] rv_w;
  logic signed [35:0] lag_w;
  logic signed [35:0] two_d;
  logic signed [35:0] win_p;
  logic signed [35:0] win_n;
  logic signed [31:0] ys_pos_w;
  logic in_band, eps_gt_lag, eps_lt_cs, eps_gt_cs, below_cs_lag, above_cs_lag;
  logic in_lagp, in_lagn, eps_gt_rv, eps_lt_rv;

  // Widened operands so no compare can wrap
  assign eps_w    = {{4{eps[31]}}, eps};
  assign cs_w     = {{4{cs[31]}}, cs};
  assign rv_w     = {{4{rv[31]}}, rv};
  assign lag_w    = {5'b0, lag};
  assign ys_pos_w = {1'b0, ys_pos};

  // Window tests on doubled values
  assign two_d = (eps_w - rv_w) <<< 1;
  assign win_p = two_d + lag_w;
  assign win_n = two_d - lag_w;

  assign in_band      = (eps_w <= lag_w) && (eps_w >= -lag_w);
  assign eps_gt_lag   = eps_w > lag_w;
  assign eps_lt_cs    = eps < cs;    // sign of saturated difference
  assign eps_gt_cs    = eps > cs;
  assign below_cs_lag = eps_w < (cs_w - lag_w);
  assign above_cs_lag = eps_w > (cs_w + lag_w);
  assign in_lagp      = (win_p < lag_w) && (win_p > -lag_w);
  assign in_lagn      = (win_n < lag_w) && (win_n > -lag_w);
  assign eps_gt_rv    = eps > rv;
  assign eps_lt_rv    = eps < rv;

  // Cascade: blocks in order initial, pos, lag-pos, neg, lag-neg
  always_comb begin
    logic [2:0]         br;
    logic signed [31:0] st;
    logic signed [31:0] rev;
    logic               done;
    br   = cbr;
    st   = cur.stress;
    rev  = cur.reversal;
    done = 1'b0;

    if (br == BR_INIT) begin
      if (in_band) begin
        st = '0;
      end else if (eps_gt_lag) begin
        st = ys_pos_w;
        br = BR_POS;
      end else begin
        st = ys_neg;
        br = BR_NEG;
      end
    end

    if (br == BR_POS) begin
      if (eps_lt_cs) begin
        rev = cs;
        if (below_cs_lag) begin
          st = ys_neg;
          br = BR_NEG;
        end else begin
          st   = '0;
          br   = BR_LAGP;
          done = 1'b1;
        end
      end else begin
        st = ys_pos_w;
      end
    end

    if (!done && br == BR_LAGP) begin
      if (in_lagp) begin
        st = '0;
      end else if (eps_gt_rv) begin
        st = ys_pos_w;
        br = BR_POS;
      end else begin
        st   = ys_neg;
        br   = BR_NEG;
        done = 1'b1;
      end
    end

    if (!done && br == BR_NEG) begin
      if (eps_gt_cs) begin
        rev = cs;
        if (above_cs_lag) begin
          st = ys_pos_w;
          br = BR_POS;
        end else begin
          st   = '0;
          br   = BR_LAGN;
          done = 1'b1;
        end
      end else begin
        st = ys_neg;
      end
    end

    if (!done && br == BR_LAGN) begin
      if (in_lagn) begin
        st = '0;
      end else if (eps_lt_rv) begin
        st = ys_neg;
        br = BR_NEG;
      end else begin
        st = ys_pos_w;
        br = BR_POS;
      end
    end

    nxt.stress   = st;
    nxt.branch   = br;
    nxt.reversal = rev;
  end

endmodule

`default_nettype wire

// ===== hdl/glpm_state.sv =====
// Trial and committed state registers, updated once per advancing beat.
// Depends on glpm_pkg and glpm_cascade.
`default_nettype none

module glpm_state import glpm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire glpm_in_t           item,
  input  wire logic [30:0]        lag,
  input  wire logic [30:0]        ys_pos,
  input  wire logic signed [31:0] ys_neg,
  output glpm_out_t               result
);

  logic signed [31:0] trial_strain;
  glpm_trial_t        trial;
  logic signed [31:0] committed_strain;
  glpm_trial_t        committed;
  glpm_trial_t        evaluated;

  glpm_cascade u_cascade (
    .eps    (item.strain),
    .cs     (committed_strain),
    .rv     (committed.reversal),
    .cbr    (committed.branch),
    .lag    (lag),
    .ys_pos (ys_pos),
    .ys_neg (ys_neg),
    .cur    (trial),
    .nxt    (evaluated)
  );

  // State update per item kind
  always_ff @(posedge clk) begin
    if (rst) begin
      trial_strain     <= '0;
      trial            <= '{stress: '0, branch: BR_INIT, reversal: '0};
      committed_strain <= '0;
      committed        <= '{stress: '0, branch: BR_INIT, reversal: '0};
    end else if (advance) begin
      case (item.kind)
        KIND_TRIAL: begin
          trial_strain <= item.strain;
          trial        <= evaluated;
        end
        KIND_COMMIT: begin
          committed_strain <= trial_strain;
          committed        <= trial;
        end
        KIND_REVERT: begin
          trial_strain <= committed_strain;
          trial        <= committed;
        end
        default: begin
          trial_strain     <= '0;
          trial            <= '{stress: '0, branch: BR_INIT, reversal: '0};
          committed_strain <= '0;
          committed        <= '{stress: '0, branch: BR_INIT, reversal: '0};
        end
      endcase
    end
  end

  // Result beat reports the trial state
  assign result.stress          = trial.stress;
  assign result.branch          = trial.branch;
  assign result.reversal_strain = trial.reversal;

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.kind == KIND_RESTART |=>
      trial.branch == BR_INIT && committed.branch == BR_INIT && trial_strain == '0)
    else $error("restart did not clear state");

  a_commit_copies: assert property (@(posedge clk) disable iff (rst)
    advance && item.kind == KIND_COMMIT |=>
      committed_strain == $past(trial_strain) && committed == $past(trial))
    else $error("commit did not copy trial state");

  a_revert_copies: assert property (@(posedge clk) disable iff (rst)
    advance && item.kind == KIND_REVERT |=>
      trial_strain == $past(committed_strain) && trial == $past(committed))
    else $error("revert did not restore committed state");

  a_slack_zero: assert property (@(posedge clk) disable iff (rst)
    (trial.branch == BR_INIT || trial.branch == BR_LAGP || trial.branch == BR_LAGN)
      |-> trial.stress == '0)
    else $error("nonzero stress on a slack branch");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(trial) && $stable(committed))
    else $error("state changed without an item");

endmodule

`default_nettype wire

// ===== hdl/gap_lag_plastic_material_point.sv =====
// Slack-and-yield material point: an input beat passes through the input register, then one
// cascade evaluation into the state/result register, before its result beat appears.
// Throughput 1 item per cycle while the result side does not stall.
// An input register holds one beat while a result waits; further beats stall until it is taken.
// Synchronous active-high reset clears all trial and committed state and
// restores register defaults (yield stresses 0, lag width 0.05).
`default_nettype none

module gap_lag_plastic_material_point import glpm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire glpm_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output glpm_out_t        out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [30:0]        yield_stress_pos;
  logic signed [31:0] yield_stress_neg;
  logic [30:0]        lag_width;
  glpm_in_t           in_q;
  logic               in_q_valid;
  logic               advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      yield_stress_pos <= '0;
      yield_stress_neg <= '0;
      lag_width        <= LAG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_YIELD_POS: yield_stress_pos <= cfg_wdata[30:0];
        CFG_YIELD_NEG: yield_stress_neg <= cfg_wdata;
        CFG_LAG_WIDTH: lag_width        <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Handshake: an item moves on when the result slot is free or being taken
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  glpm_state u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .lag     (lag_width),
    .ys_pos  (yield_stress_pos),
    .ys_neg  (yield_stress_neg),
    .result  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/gap_lag_plastic_material_point_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gap_lag_plastic_material_point: strain walks with commit,
// revert and restart beats, random idling on both sides, checked against a local predictor.
// Depends on glpm_pkg and the gap_lag_plastic_material_point RTL only.

import glpm_pkg::*;

// Tracks trial/committed state of the material point and the stress beats it must produce
class yield_branch_tracker;
  longint yield_pos, yield_neg, lag;
  longint trial_eps, trial_sig, trial_rev;
  logic [2:0] trial_br;
  longint held_eps, held_sig, held_rev;
  logic [2:0] held_br;
  glpm_out_t predicted_beats[$];
  int mismatches;

  function new();
    yield_pos = 0;
    yield_neg = 0;
    lag = longint'(LAG_RESET);
    mismatches = 0;
    clear_point();
  endfunction

  function void clear_point();
    trial_eps = 0;
    trial_sig = 0;
    trial_br = BR_INIT;
    trial_rev = 0;
    held_eps = 0;
    held_sig = 0;
    held_br = BR_INIT;
    held_rev = 0;
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] val);
    case (idx)
      CFG_YIELD_POS: yield_pos = longint'(val[30:0]);
      CFG_YIELD_NEG: yield_neg = longint'($signed(val));
      CFG_LAG_WIDTH: lag = longint'(val[30:0]);
      default: ;
    endcase
  endfunction

  function longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Branch cascade for one trial strain, starting from the committed branch
  function void step_branch_cascade(longint eps);
    longint cs, rv, deps;
    logic [2:0] br;
    cs = held_eps;
    rv = held_rev;
    br = held_br;
    deps = eps - cs;
    if (deps > 64'sd2147483647) deps = 64'sd2147483647;
    if (deps < -64'sd2147483648) deps = -64'sd2147483648;
    trial_eps = eps;

    if (br == BR_INIT) begin
      if (magnitude(eps) <= lag) begin
        trial_sig = 0;
      end else if (eps > lag) begin
        trial_sig = yield_pos;
        br = BR_POS;
      end else begin
        trial_sig = yield_neg;
        br = BR_NEG;
      end
    end
    // positive yield: unloading records the reversal
    if (br == BR_POS) begin
      if (deps < 0) begin
        trial_rev = cs;
        if (eps < cs - lag) begin
          trial_sig = yield_neg;
          br = BR_NEG;
        end else begin
          trial_sig = 0;
          trial_br = BR_LAGP;
          return;
        end
      end else begin
        trial_sig = yield_pos;
      end
    end
    // lag window (R - lag, R), tested on doubled values
    if (br == BR_LAGP) begin
      if (magnitude(2 * (eps - rv) + lag) < lag) begin
        trial_sig = 0;
      end else if (eps > rv) begin
        trial_sig = yield_pos;
        br = BR_POS;
      end else begin
        trial_sig = yield_neg;
        trial_br = BR_NEG;
        return;
      end
    end
    // negative yield: reloading records the reversal
    if (br == BR_NEG) begin
      if (deps > 0) begin
        trial_rev = cs;
        if (eps > cs + lag) begin
          trial_sig = yield_pos;
          br = BR_POS;
        end else begin
          trial_sig = 0;
          trial_br = BR_LAGN;
          return;
        end
      end else begin
        trial_sig = yield_neg;
      end
    end
    // lag window (R, R + lag)
    if (br == BR_LAGN) begin
      if (magnitude(2 * (eps - rv) - lag) < lag) begin
        trial_sig = 0;
      end else if (eps < rv) begin
        trial_sig = yield_neg;
        br = BR_NEG;
      end else begin
        trial_sig = yield_pos;
        br = BR_POS;
      end
    end
    trial_br = br;
  endfunction

  // Accepted input beat: update state and queue the stress beat it causes
  function void note_item(glpm_in_t beat);
    glpm_out_t want;
    case (beat.kind)
      KIND_TRIAL: step_branch_cascade(longint'($signed(beat.strain)));
      KIND_COMMIT: begin
        held_eps = trial_eps;
        held_sig = trial_sig;
        held_br = trial_br;
        held_rev = trial_rev;
      end
      KIND_REVERT: begin
        trial_eps = held_eps;
        trial_sig = held_sig;
        trial_br = held_br;
        trial_rev = held_rev;
      end
      default: clear_point();
    endcase
    want.stress = trial_sig[31:0];
    want.branch = trial_br;
    want.reversal_strain = trial_rev[31:0];
    predicted_beats.push_back(want);
  endfunction

  // Accepted result beat: compare against the oldest prediction
  function void check_result(glpm_out_t got);
    glpm_out_t want;
    if (predicted_beats.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result beat: stress %h branch %0d reversal %h",
                 got.stress, got.branch, got.reversal_strain);
      mismatches++;
      return;
    end
    want = predicted_beats.pop_front();
    if (got.stress !== want.stress || got.branch !== want.branch ||
        got.reversal_strain !== want.reversal_strain) begin
      if (mismatches < 10)
        $display("mismatch (exp/got): stress %h/%h branch %0d/%0d reversal %h/%h",
                 want.stress, got.stress, want.branch, got.branch,
                 want.reversal_strain, got.reversal_strain);
      mismatches++;
    end
  endfunction

  function int pending();
    return predicted_beats.size();
  endfunction
endclass

module gap_lag_plastic_material_point_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  glpm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  glpm_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_YIELD_POS;
  logic [31:0] cfg_wdata = '0;

  yield_branch_tracker tracker;
  int in_idle_pct = 36;
  int out_idle_pct = 36;
  bit hold_req = 1'b0;
  int hold_left = 0;
  longint walk_base = 0;
  longint walk_dir = 1;

  always #6 clk = ~clk;

  gap_lag_plastic_material_point uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Result side: check accepted beats, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_data);
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one input beat, with a random idle gap first, and hold it until taken
  task automatic offer(input logic [1:0] kind, input logic [31:0] strain);
    glpm_in_t beat;
    beat.kind = kind;
    beat.strain = strain;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    tracker.note_item(beat);
  endtask

  // Stop sending and wait for every predicted beat, plus the pipeline latency
  task automatic pause_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] ypos, input logic [31:0] yneg,
                                input logic [31:0] lagw);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_YIELD_POS;
    cfg_wdata <= ypos;
    @(posedge clk);
    tracker.set_register(CFG_YIELD_POS, ypos);
    cfg_index <= CFG_YIELD_NEG;
    cfg_wdata <= yneg;
    @(posedge clk);
    tracker.set_register(CFG_YIELD_NEG, yneg);
    cfg_index <= CFG_LAG_WIDTH;
    cfg_wdata <= lagw;
    @(posedge clk);
    tracker.set_register(CFG_LAG_WIDTH, lagw);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic longint rand_upto(longint hi);
    longint v;
    v = {$urandom, $urandom};
    v[63] = 1'b0;
    return v % (hi + 1);
  endfunction

  // Loading/unloading walk around the committed strain, with some noise beats
  task automatic walk_phase(input int count);
    int sent, r;
    longint span, stepv, target;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 6) begin
        offer(KIND_TRIAL, $urandom);
        sent++;
      end else if (r < 9) begin
        offer(KIND_REVERT, $urandom);
        sent++;
      end else if (r < 11) begin
        offer(KIND_RESTART, $urandom);
        walk_base = 0;
        sent++;
      end else begin
        span = (tracker.lag == 0) ? 64'sd1048576 : tracker.lag;
        if ($urandom_range(99) < 15) walk_dir = -walk_dir;
        case ($urandom_range(3))
          0: stepv = rand_upto(span);
          1: stepv = rand_upto(3 * span);
          2: stepv = span - 1 + $urandom_range(2);   // right at the window edge
          default: stepv = $urandom_range(15);
        endcase
        if ($urandom_range(99) < 20) stepv = -stepv;
        target = walk_base + walk_dir * stepv;
        if (target > 64'sd2147483647) target = 64'sd2147483647;
        if (target < -64'sd2147483648) target = -64'sd2147483648;
        offer(KIND_TRIAL, target[31:0]);
        sent++;
        if ($urandom_range(99) < 70) begin
          offer(KIND_COMMIT, $urandom);
          walk_base = target;
          sent++;
        end
      end
    end
  endtask

  initial begin
    int lw;
    tracker = new();
    lw = int'(LAG_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: slack band edges, both reversals, window edges, saturation, restart
    apply_settings(32'h0064_0000, 32'hFFB0_0000, {1'b0, LAG_RESET});
    offer(KIND_TRIAL, 0);
    offer(KIND_TRIAL, lw);
    offer(KIND_TRIAL, -lw);
    offer(KIND_TRIAL, lw + 1);
    offer(KIND_COMMIT, 0);
    offer(KIND_TRIAL, 2 * lw);
    offer(KIND_COMMIT, 0);
    offer(KIND_TRIAL, 2 * lw - lw / 2);
    offer(KIND_COMMIT, 0);
    offer(KIND_TRIAL, 2 * lw - lw / 4);
    offer(KIND_TRIAL, lw);
    offer(KIND_TRIAL, lw + 1);
    offer(KIND_REVERT, 0);
    offer(KIND_TRIAL, -5 * lw);
    offer(KIND_COMMIT, 0);
    offer(KIND_TRIAL, -5 * lw + lw / 2);
    offer(KIND_COMMIT, 0);
    offer(KIND_TRIAL, -4 * lw);
    offer(KIND_TRIAL, -6 * lw);
    offer(KIND_RESTART, 32'hFFFF_FFFF);
    offer(KIND_TRIAL, 32'h8000_0000);
    offer(KIND_COMMIT, 0);
    offer(KIND_TRIAL, 32'h7FFF_FFFF);
    offer(KIND_COMMIT, 0);
    offer(KIND_TRIAL, 32'h8000_0000);
    offer(KIND_RESTART, 0);
    pause_for_results();

    // Default lag, long receiver hold-off while the sender keeps offering
    apply_settings($urandom_range(32'h7FFF_FFFF), -$urandom_range(32'h7FFF_FFFF),
                   {1'b0, LAG_RESET});
    hold_req = 1'b1;
    walk_phase(120);
    pause_for_results();

    // Extremes: zero lag, full-scale yield stresses, no idling on either side
    in_idle_pct = 0;
    out_idle_pct = 0;
    apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    walk_phase(120);
    pause_for_results();

    // Small random lag, sender pauses midway until all results are in
    in_idle_pct = 36;
    out_idle_pct = 36;
    apply_settings($urandom_range(32'h7FFF_FFFF), -$urandom_range(32'h7FFF_FFFF),
                   $urandom_range(1, 32'h0040_0000));
    walk_phase(60);
    pause_for_results();
    walk_phase(60);
    pause_for_results();

    // Maximum lag, zero yield stresses
    apply_settings(32'h0, 32'h0, 32'h7FFF_FFFF);
    walk_phase(60);
    pause_for_results();

    // Minimal lag, negative-yield register written with a positive value
    apply_settings($urandom_range(32'h7FFF_FFFF), $urandom_range(1, 32'h7FFF_FFFF), 32'h1);
    walk_phase(100);
    pause_for_results();

    // Wide random lag, second hold-off
    apply_settings($urandom_range(32'h7FFF_FFFF), -$urandom_range(32'h7FFF_FFFF),
                   $urandom_range(32'h1000_0000));
    hold_req = 1'b1;
    walk_phase(180);
    pause_for_results();
    repeat (8) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
